FILE: rtl/llt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llt_pkg
// Shared types and constants for the longest-lines top-k tracker.
// ----------------------------------------------------------------------------
package llt_pkg;

    localparam int LEN_W      = 10;
    localparam int TAG_W      = 16;
    localparam int KEEP_W     = 5;
    localparam int IN_DATA_W  = 32;   // length + tag, padded to bytes
    localparam int OUT_DATA_W = 32;   // tag + length, padded to bytes

    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    // request kinds carried on s_axis_tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_REPORT = 1'b1;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [TAG_W-1:0] tag;
    } llt_entry_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic clear;
        logic insert;
        logic rotate;
    } llt_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/llt_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// llt_cell
// One rank of the sorted chain: holds a (length, tag) pair, compares it with
// the offered line and takes the new line, its upstream neighbor, or the
// downstream neighbor when the chain rotates for a report.
// ----------------------------------------------------------------------------
module llt_cell (
    input  wire                      clk,
    input  wire                      rst_n,
    input  llt_pkg::llt_ctrl_t       ctrl,
    input  wire                      active,     // rank below the kept count
    input  llt_pkg::llt_entry_t      new_entry,  // offered line
    input  llt_pkg::llt_entry_t      prev_entry, // neighbor one rank up
    input  wire                      prev_less,  // neighbor one rank up loses
    input  llt_pkg::llt_entry_t      next_entry, // rotate source
    output llt_pkg::llt_entry_t      entry,
    output logic                     less
);
    import llt_pkg::*;

    llt_entry_t entry_reg;
    llt_entry_t entry_next;

    assign entry = entry_reg;
    assign less  = entry_reg.len < new_entry.len;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.clear)
        begin
            entry_next = '0;
        end
        else if (ctrl.insert && active)
        begin
            // upstream already lost, so this rank shifts down
            if (prev_less)
                entry_next = prev_entry;
            else if (less)
                entry_next = new_entry;
        end
        else if (ctrl.rotate && active)
        begin
            entry_next = next_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

endmodule
`default_nettype wire

FILE: rtl/longest_lines_top_k_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// longest_lines_top_k_tracker
// Keeps the keep_count longest lines in descending length order and reports
// them on request.
// ----------------------------------------------------------------------------
// In an insert transaction (tuser = 0) all cells compare against the offered
// length in parallel and the ranks below the insertion point shift down one
// rank in the same edge, so inserts can arrive back to back. A report transaction
// (tuser = 1) rotates the chain one rank per cycle through the output register
// and emits keep_count entries (1..MAX_KEPT after clamping), best first, with
// tlast on the final one; output backpressure stretches this, and no input
// is taken until the last entry has been loaded into the output register.
// A keep_count write empties all ranks.
// ----------------------------------------------------------------------------
module longest_lines_top_k_tracker #(
    parameter int MAX_KEPT   = 16,
    parameter int LINE_LIMIT = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    // config: keep_count
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [4:0]  cfg_data,
    // input items
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,  // [9:0] line_length, [25:10] line_tag
    input  wire         s_axis_tuser,  // [0] req_type
    // result items
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata,  // [15:0] entry_tag, [25:16] entry_length
    output logic        m_axis_tuser,  // [0] entry_valid
    output logic        m_axis_tlast   // last_entry
);
    import llt_pkg::*;

    localparam int CNT_W = $clog2(MAX_KEPT + 1);
    localparam int LEN_CAP_I = (LINE_LIMIT - 1 > 1023) ? 1023 : LINE_LIMIT - 1;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_REPORT = 2'b10
    } state_t;

    state_t            state_reg, state_next;
    logic [KEEP_W-1:0] keep_count_reg;
    logic [CNT_W-1:0]  rep_cnt_reg, rep_cnt_next;
    logic [CNT_W-1:0]  k_active;

    logic              out_valid_reg, out_valid_next;
    llt_entry_t        out_entry_reg;
    logic              out_last_reg;

    logic              in_accept;
    logic              cfg_accept;
    logic              out_load;
    logic              rep_done;
    logic [LEN_W-1:0]  in_len;
    llt_entry_t        new_entry;
    llt_ctrl_t         ctrl;

    llt_entry_t        cell_q [MAX_KEPT];
    logic [MAX_KEPT-1:0] less_q;

    // clamp keep_count to 1..MAX_KEPT
    always_comb
    begin
        if (keep_count_reg == '0)
            k_active = CNT_W'(1);
        else if (int'(keep_count_reg) > MAX_KEPT)
            k_active = CNT_W'(MAX_KEPT);
        else
            k_active = CNT_W'(keep_count_reg);
    end

    assign cfg_ready     = 1'b1;
    assign cfg_accept    = cfg_valid && cfg_ready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    assign in_len = (s_axis_tdata[LEN_W-1:0] > LEN_CAP) ? LEN_CAP
                                                         : s_axis_tdata[LEN_W-1:0];
    assign new_entry.len = in_len;
    assign new_entry.tag = s_axis_tdata[LEN_W +: TAG_W];

    assign out_load = (state_reg == ST_REPORT) && (!out_valid_reg || m_axis_tready);
    assign rep_done = (rep_cnt_reg == CNT_W'(k_active - CNT_W'(1)));

    assign ctrl.clear  = cfg_accept;
    assign ctrl.insert = in_accept && (s_axis_tuser == REQ_INSERT) && (in_len != '0);
    assign ctrl.rotate = out_load;

    // cell chain
    for (genvar i = 0; i < MAX_KEPT; i++)
    begin : g_cell
        llt_entry_t prev_e;
        llt_entry_t next_e;
        logic       prev_l;
        logic       active;
        logic       is_last;

        assign active  = CNT_W'(i) < k_active;
        assign is_last = CNT_W'(i + 1) == k_active;

        if (i == 0)
        begin : g_head
            assign prev_e = '0;
            assign prev_l = 1'b0;
        end
        else
        begin : g_body
            assign prev_e = cell_q[i-1];
            assign prev_l = less_q[i-1];
        end

        // the last active rank wraps around to the head
        assign next_e = is_last ? cell_q[0] : cell_q[(i + 1) % MAX_KEPT];

        llt_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .active     (active),
            .new_entry  (new_entry),
            .prev_entry (prev_e),
            .prev_less  (prev_l),
            .next_entry (next_e),
            .entry      (cell_q[i]),
            .less       (less_q[i])
        );
    end

    always_comb
    begin
        state_next   = state_reg;
        rep_cnt_next = rep_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (s_axis_tuser == REQ_REPORT))
                begin
                    state_next   = ST_REPORT;
                    rep_cnt_next = '0;
                end
            end
            ST_REPORT:
            begin
                if (out_load)
                begin
                    rep_cnt_next = rep_cnt_reg + CNT_W'(1);
                    if (rep_done)
                        state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rep_cnt_reg    <= '0;
            keep_count_reg <= KEEP_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rep_cnt_reg   <= rep_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_accept)
                keep_count_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_entry_reg <= cell_q[0];
            out_last_reg  <= rep_done;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = (out_entry_reg.len != '0);
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_entry_reg.len,
                            m_axis_tuser ? out_entry_reg.tag : {TAG_W{1'b0}}};

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------
    a_report_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (s_axis_tuser == REQ_REPORT)) |=> (state_reg == ST_REPORT))
        else $error("report transaction did not start readout");

    a_last_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && rep_done) |=> (m_axis_tvalid && m_axis_tlast))
        else $error("final report entry not marked last");

    a_no_early_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && !rep_done) |=> (m_axis_tvalid && !m_axis_tlast))
        else $error("tlast raised before final report entry");

    a_empty_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("empty slot reported with nonzero data");

endmodule
`default_nettype wire
